// ===== sv/pcwrl_pkg.sv =====
// Package for the per-client window rate limiter.
// Holds the field widths, the register index and decision codes, and the payload types.
// Has no dependencies. The interfaces and the top level use it.
package pcwrl_pkg;

  localparam int unsigned ClientW = 22;
  localparam int unsigned CountW  = 8;
  localparam int unsigned WindowW = 24;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_LIMITING_ENABLED = 2'd0,
    CFG_LIMIT_MAX        = 2'd1,
    CFG_WINDOW_TICKS     = 2'd2
  } cfg_addr_e;

  typedef enum logic {
    REQ_COMMAND = 1'b0,
    REQ_TICK    = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    DEC_ALLOWED    = 2'd0,
    DEC_OVER_LIMIT = 2'd1,
    DEC_TABLE_FULL = 2'd2
  } decision_e;

  localparam logic [CountW-1:0]  LimitMaxReset    = 8'd10;
  localparam logic [WindowW-1:0] WindowTicksReset = 24'd1000;

  typedef struct packed {
    logic              allowed;
    decision_e         decision;
    logic [CountW-1:0] count_now;
  } rsp_t;

endpackage

// ===== sv/pcwrl_intf.sv =====
// Channel interfaces for the per-client window rate limiter.
// A request channel, a result channel and a configuration write channel.
// They depend on pcwrl_pkg for field widths and codes.
interface pcwrl_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [pcwrl_pkg::ClientW-1:0] client_id;

  modport source (output valid, output req_type, output client_id, input ready);
  modport sink   (input valid, input req_type, input client_id, output ready);
endinterface

interface pcwrl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic [1:0]                   decision;
  logic [pcwrl_pkg::CountW-1:0] count_now;

  modport source (output valid, output allowed, output decision, output count_now,
                  input ready);
  modport sink   (input valid, input allowed, input decision, input count_now,
                  output ready);
endinterface

interface pcwrl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcwrl_pkg::CfgAddrW-1:0] addr;
  logic [pcwrl_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== sv/per_client_window_rate_limiter.sv =====
// Per-client fixed-window rate limiter, top level.
// Depends on pcwrl_pkg and on the channel interfaces in pcwrl_intf.sv.
//
// One request is accepted per cycle unless stalled: a command request looks up its
// client in a table of TABLE_ENTRIES entries with a parallel compare, and
// its result stands in the result register in the cycle after acceptance. A
// tick request gives no result. The result register is the only buffer, so
// a request is accepted whenever that register is empty or is being drained
// in the same cycle. The table is held in flip-flops with one valid bit per
// entry, so reset and window expiry clear it at once, with no clearing pass.
// Configuration writes are always taken and act on the next request.
module per_client_window_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcwrl_cfg_if.sink         cfg_i,
  pcwrl_req_if.sink         req_i,
  pcwrl_rsp_if.source       rsp_o
);

  localparam int unsigned N = TABLE_ENTRIES;

  // Configuration registers.
  logic                                limiting_enabled_q;
  logic [pcwrl_pkg::CountW-1:0]        limit_max_q;
  logic [pcwrl_pkg::WindowW-1:0]       window_ticks_q;

  // Table and window timer.
  logic [N-1:0]                        entry_valid_q, entry_valid_d;
  logic [pcwrl_pkg::ClientW-1:0]       entry_client_q [N];
  logic [pcwrl_pkg::CountW-1:0]        entry_count_q  [N];
  logic [pcwrl_pkg::WindowW-1:0]       window_counter_q, window_counter_d;

  // Result register.
  logic                                rsp_valid_q, rsp_valid_d;
  pcwrl_pkg::rsp_t                     rsp_q, rsp_d;

  logic                                cfg_write;
  logic                                req_accept;
  logic                                is_command;
  logic                                is_tick;
  logic [N-1:0]                        hit_vec, hit_oh, free_vec, free_oh;
  logic                                any_hit, any_free;
  logic [pcwrl_pkg::CountW-1:0]        hit_count;
  logic [pcwrl_pkg::WindowW-1:0]       window_next;
  logic                                write_hit, write_new;
  logic [pcwrl_pkg::CountW-1:0]        hit_count_inc;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid & cfg_i.ready;

  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign req_accept  = req_i.valid & req_i.ready;
  assign is_command  = req_accept & (req_i.req_type == pcwrl_pkg::REQ_COMMAND);
  assign is_tick     = req_accept & (req_i.req_type == pcwrl_pkg::REQ_TICK);

  // Parallel lookup. Client ids in the table are unique, but the lowest
  // hit is still isolated so that the count mux sees a one-hot select.
  always_comb begin
    for (int unsigned i = 0; i < N; i++) begin
      hit_vec[i] = entry_valid_q[i] & (entry_client_q[i] == req_i.client_id);
    end
  end

  assign free_vec = ~entry_valid_q;
  assign hit_oh   = hit_vec & (~hit_vec + N'(1));
  assign free_oh  = free_vec & (~free_vec + N'(1));
  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;

  always_comb begin
    hit_count = '0;
    for (int unsigned i = 0; i < N; i++) begin
      hit_count = hit_count | (entry_count_q[i] & {pcwrl_pkg::CountW{hit_oh[i]}});
    end
  end

  assign hit_count_inc = hit_count + pcwrl_pkg::CountW'(1);
  assign window_next   = window_counter_q + pcwrl_pkg::WindowW'(1);

  // Decision and the table and timer updates.
  always_comb begin
    entry_valid_d    = entry_valid_q;
    window_counter_d = window_counter_q;
    write_hit        = 1'b0;
    write_new        = 1'b0;
    rsp_d            = rsp_q;
    rsp_valid_d      = rsp_valid_q & ~rsp_o.ready;

    if (is_command) begin
      rsp_valid_d = 1'b1;
      if (!limiting_enabled_q) begin
        rsp_d.allowed   = 1'b1;
        rsp_d.decision  = pcwrl_pkg::DEC_ALLOWED;
        rsp_d.count_now = '0;
      end else if (any_hit) begin
        if (hit_count >= limit_max_q) begin
          rsp_d.allowed   = 1'b0;
          rsp_d.decision  = pcwrl_pkg::DEC_OVER_LIMIT;
          rsp_d.count_now = hit_count;
        end else begin
          write_hit       = 1'b1;
          rsp_d.allowed   = 1'b1;
          rsp_d.decision  = pcwrl_pkg::DEC_ALLOWED;
          rsp_d.count_now = hit_count_inc;
        end
      end else if (any_free) begin
        write_new       = 1'b1;
        entry_valid_d   = entry_valid_q | free_oh;
        rsp_d.allowed   = 1'b1;
        rsp_d.decision  = pcwrl_pkg::DEC_ALLOWED;
        rsp_d.count_now = pcwrl_pkg::CountW'(1);
      end else begin
        rsp_d.allowed   = 1'b0;
        rsp_d.decision  = pcwrl_pkg::DEC_TABLE_FULL;
        rsp_d.count_now = '0;
      end
    end

    if (is_tick && limiting_enabled_q) begin
      if (window_next >= window_ticks_q || window_counter_q >= window_ticks_q) begin
        entry_valid_d    = '0;
        window_counter_d = '0;
      end else begin
        window_counter_d = window_next;
      end
    end

    // Turning limiting off empties the table and stops the timer.
    if (cfg_write && cfg_i.addr == pcwrl_pkg::CFG_LIMITING_ENABLED && !cfg_i.wdata[0]) begin
      entry_valid_d    = '0;
      window_counter_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limiting_enabled_q <= 1'b0;
      limit_max_q        <= pcwrl_pkg::LimitMaxReset;
      window_ticks_q     <= pcwrl_pkg::WindowTicksReset;
    end else if (cfg_write) begin
      unique case (cfg_i.addr)
        pcwrl_pkg::CFG_LIMITING_ENABLED: limiting_enabled_q <= cfg_i.wdata[0];
        pcwrl_pkg::CFG_LIMIT_MAX:        limit_max_q <= cfg_i.wdata[pcwrl_pkg::CountW-1:0];
        pcwrl_pkg::CFG_WINDOW_TICKS:     window_ticks_q <= cfg_i.wdata[pcwrl_pkg::WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q    <= '0;
      window_counter_q <= '0;
      rsp_valid_q      <= 1'b0;
    end else begin
      entry_valid_q    <= entry_valid_d;
      window_counter_q <= window_counter_d;
      rsp_valid_q      <= rsp_valid_d;
    end
  end

  // Table payload and result payload need no reset.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    for (int unsigned i = 0; i < N; i++) begin
      if (write_new && free_oh[i]) begin
        entry_client_q[i] <= req_i.client_id;
        entry_count_q[i]  <= pcwrl_pkg::CountW'(1);
      end else if (write_hit && hit_oh[i]) begin
        entry_count_q[i]  <= hit_count_inc;
      end
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.allowed   = rsp_q.allowed;
  assign rsp_o.decision  = rsp_q.decision;
  assign rsp_o.count_now = rsp_q.count_now;

  // While limiting is off, the table is empty and the timer stands at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !limiting_enabled_q |-> (entry_valid_q == '0 && window_counter_q == '0))
    else $error("table or timer not clear while limiting is disabled");

  // An accepted command always produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_command |=> rsp_valid_q)
    else $error("command request produced no result");

  // A tick never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> !rsp_valid_q)
    else $error("tick request produced a result");

  // The allowed flag agrees with the decision code, and a full-table denial
  // carries a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> ((rsp_q.allowed == (rsp_q.decision == pcwrl_pkg::DEC_ALLOWED)) &&
                     (rsp_q.decision != pcwrl_pkg::DEC_TABLE_FULL || rsp_q.count_now == '0)))
    else $error("inconsistent result fields");

  // A new client is only entered when it matched no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_new |-> (!any_hit && $onehot(free_oh)))
    else $error("new entry written for a known client");

endmodule

// ===== tb/per_client_window_rate_limiter_test.sv =====
// Self-checking testbench for the per-client window rate limiter.
// Drives the request and configuration channels, predicts every verdict
// with a shadow client table. Depends on pcwrl_pkg and pcwrl_intf.sv.
module per_client_window_rate_limiter_test;

  localparam int unsigned Slots      = 16;
  localparam int unsigned CycleLimit = 500000;

  // Shadow copy of the client table and window timer; keeps the verdicts
  // still owed by the block in arrival order.
  class rate_window_book;
    logic                            enabled;
    logic [pcwrl_pkg::CountW-1:0]    limit;
    logic [pcwrl_pkg::WindowW-1:0]   window;
    logic                            slot_used   [Slots];
    logic [pcwrl_pkg::ClientW-1:0]   slot_client [Slots];
    logic [pcwrl_pkg::CountW-1:0]    slot_count  [Slots];
    logic [pcwrl_pkg::WindowW-1:0]   tick_count;
    pcwrl_pkg::rsp_t                 verdicts_due [$];
    int unsigned                     mismatches;

    function new();
      enabled    = 1'b0;
      limit      = pcwrl_pkg::LimitMaxReset;
      window     = pcwrl_pkg::WindowTicksReset;
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (slot_used[i]) begin
        slot_used[i]   = 1'b0;
        slot_client[i] = '0;
        slot_count[i]  = '0;
      end
      tick_count = '0;
    endfunction

    function void apply_register(logic [pcwrl_pkg::CfgAddrW-1:0] addr,
                                 logic [pcwrl_pkg::CfgDataW-1:0] data);
      case (addr)
        pcwrl_pkg::CFG_LIMITING_ENABLED: begin
          enabled = data[0];
          if (!data[0]) wipe();
        end
        pcwrl_pkg::CFG_LIMIT_MAX:    limit  = data[pcwrl_pkg::CountW-1:0];
        pcwrl_pkg::CFG_WINDOW_TICKS: window = data[pcwrl_pkg::WindowW-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic kind, logic [pcwrl_pkg::ClientW-1:0] client);
      int                            hit_slot;
      int                            free_slot;
      logic [pcwrl_pkg::WindowW-1:0] next_count;
      pcwrl_pkg::rsp_t               verdict;
      hit_slot  = -1;
      free_slot = -1;
      if (kind == pcwrl_pkg::REQ_TICK) begin
        if (enabled) begin
          next_count = tick_count + 1'b1;
          // A window lowered below the running count also expires here.
          if (next_count >= window || tick_count >= window) wipe();
          else tick_count = next_count;
        end
        return;
      end
      verdict.allowed   = 1'b1;
      verdict.decision  = pcwrl_pkg::DEC_ALLOWED;
      verdict.count_now = '0;
      if (enabled) begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_used[i]) begin
            if (hit_slot < 0 && slot_client[i] == client) hit_slot = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit_slot >= 0) begin
          if (slot_count[hit_slot] >= limit) begin
            verdict.allowed   = 1'b0;
            verdict.decision  = pcwrl_pkg::DEC_OVER_LIMIT;
            verdict.count_now = slot_count[hit_slot];
          end else begin
            slot_count[hit_slot] = slot_count[hit_slot] + 1'b1;
            verdict.count_now    = slot_count[hit_slot];
          end
        end else if (free_slot >= 0) begin
          slot_used[free_slot]   = 1'b1;
          slot_client[free_slot] = client;
          slot_count[free_slot]  = pcwrl_pkg::CountW'(1);
          verdict.count_now      = pcwrl_pkg::CountW'(1);
        end else begin
          verdict.allowed  = 1'b0;
          verdict.decision = pcwrl_pkg::DEC_TABLE_FULL;
        end
      end
      verdicts_due.push_back(verdict);
    endfunction

    function void check_verdict(logic allowed, logic [1:0] decision,
                                logic [pcwrl_pkg::CountW-1:0] count_now);
      pcwrl_pkg::rsp_t want;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result: allowed %0d decision %0d count_now %0d",
               allowed, decision, count_now);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      if (allowed !== want.allowed) begin
        $error("allowed: expected %0d, actual %0d", want.allowed, allowed);
        mismatches++;
      end
      if (decision !== want.decision) begin
        $error("decision: expected %0d, actual %0d", want.decision, decision);
        mismatches++;
      end
      if (count_now !== want.count_now) begin
        $error("count_now: expected %0d, actual %0d", want.count_now, count_now);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pcwrl_req_if req_if ();
  pcwrl_rsp_if rsp_if ();
  pcwrl_cfg_if cfg_if ();

  per_client_window_rate_limiter #(
    .TABLE_ENTRIES(Slots)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  rate_window_book book = new();

  int unsigned cycle_count = 0;
  int unsigned hold_order  = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  bit          send_idles  = 1'b0;
  bit          take_stalls = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("per_client_window_rate_limiter_test NOT OK");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus long hold-offs on demand.
  always @(posedge clk_i) begin
    if (hold_order != 0) begin
      hold_left  = hold_order;
      hold_order = 0;
    end
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (take_stalls && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  // Results are checked before the request of the same edge is noted, so a
  // spurious result can never consume a fresh expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        book.check_verdict(rsp_if.allowed, rsp_if.decision, rsp_if.count_now);
      if (cfg_if.valid && cfg_if.ready)
        book.apply_register(cfg_if.addr, cfg_if.wdata);
      if (req_if.valid && req_if.ready)
        book.note_request(req_if.req_type, req_if.client_id);
    end
  end

  task automatic send_request(pcwrl_pkg::req_type_e kind,
                              logic [pcwrl_pkg::ClientW-1:0] client);
    int unsigned gap;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.client_id <= client;
    do @(posedge clk_i); while (!req_if.ready);
    if (send_idles && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits for every owed verdict, then lets a tick that
  // produced no result finish inside the block.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (book.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(pcwrl_pkg::cfg_addr_e addr,
                           logic [pcwrl_pkg::CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= addr;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Unused upper data bits carry random junk that the block must ignore.
  task automatic configure(logic en, logic [pcwrl_pkg::CountW-1:0] lim,
                           logic [pcwrl_pkg::WindowW-1:0] win);
    logic [pcwrl_pkg::CfgDataW-1:0] junk;
    drain_results();
    junk = pcwrl_pkg::CfgDataW'($urandom);
    cfg_write(pcwrl_pkg::CFG_LIMIT_MAX,
              {junk[pcwrl_pkg::CfgDataW-1:pcwrl_pkg::CountW], lim});
    cfg_write(pcwrl_pkg::CFG_WINDOW_TICKS, win);
    junk = pcwrl_pkg::CfgDataW'($urandom);
    cfg_write(pcwrl_pkg::CFG_LIMITING_ENABLED, {junk[pcwrl_pkg::CfgDataW-1:1], en});
    cfg_if.valid <= 1'b0;
  endtask

  // Commands mostly come from a small pool of clients so that entries are
  // reused, limits are hit and the table can fill up.
  task automatic random_traffic(int unsigned n, int unsigned pool_size,
                                int unsigned tick_pct);
    logic [pcwrl_pkg::ClientW-1:0] pool [$];
    logic [pcwrl_pkg::ClientW-1:0] id;
    int unsigned                   r;
    repeat (pool_size) begin
      r = $urandom_range(0, 9);
      if (r == 0) pool.push_back('0);
      else if (r == 1) pool.push_back({pcwrl_pkg::ClientW{1'b1}});
      else pool.push_back(pcwrl_pkg::ClientW'($urandom_range(0,
                                             (1 << pcwrl_pkg::ClientW) - 1)));
    end
    repeat (n) begin
      r  = $urandom_range(0, 99);
      id = pcwrl_pkg::ClientW'($urandom_range(0, (1 << pcwrl_pkg::ClientW) - 1));
      if (r < tick_pct) begin
        send_request(pcwrl_pkg::REQ_TICK, id);
      end else begin
        if (r < 96) id = pool[$urandom_range(0, pool.size() - 1)];
        send_request(pcwrl_pkg::REQ_COMMAND, id);
      end
    end
  endtask

  initial begin
    logic                          en;
    logic [pcwrl_pkg::CountW-1:0]  lim;
    logic [pcwrl_pkg::WindowW-1:0] win;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= pcwrl_pkg::REQ_COMMAND;
    req_if.client_id <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.addr      <= pcwrl_pkg::CFG_LIMITING_ENABLED;
    cfg_if.wdata     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Limiting off after reset: everything is allowed, ticks do nothing.
    send_request(pcwrl_pkg::REQ_COMMAND, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, {pcwrl_pkg::ClientW{1'b1}});
    send_request(pcwrl_pkg::REQ_TICK, {pcwrl_pkg::ClientW{1'b1}});

    // Counting up to the limit, over-limit denial, window expiry.
    configure(1'b1, 8'd2, 24'd3);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, {pcwrl_pkg::ClientW{1'b1}});
    send_request(pcwrl_pkg::REQ_TICK, '0);
    send_request(pcwrl_pkg::REQ_TICK, '0);
    send_request(pcwrl_pkg::REQ_TICK, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);

    // A limit of zero denies known clients but still admits new ones.
    configure(1'b1, 8'd0, 24'd3);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, 22'd5);

    // Window lowered below the running count expires on the next tick.
    configure(1'b1, 8'd2, 24'd1000);
    send_request(pcwrl_pkg::REQ_TICK, '0);
    send_request(pcwrl_pkg::REQ_TICK, '0);
    configure(1'b1, 8'd2, 24'd1);
    send_request(pcwrl_pkg::REQ_TICK, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);

    // A zero-length window expires on every tick.
    configure(1'b1, 8'd2, 24'd0);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);
    send_request(pcwrl_pkg::REQ_TICK, '0);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);

    // Turning limiting off clears the table.
    configure(1'b0, 8'd10, 24'd1000);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);
    send_request(pcwrl_pkg::REQ_TICK, '0);
    configure(1'b1, 8'd10, 24'd1000);
    send_request(pcwrl_pkg::REQ_COMMAND, '0);

    for (int phase = 0; phase < 8; phase++) begin
      send_idles  = (phase % 3) != 0;
      take_stalls = (phase % 4) != 1;
      en = $urandom_range(0, 4) != 0;
      case ($urandom_range(0, 5))
        0:       lim = 8'd0;
        1:       lim = 8'd1;
        2:       lim = 8'd255;
        default: lim = pcwrl_pkg::CountW'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       win = 24'd0;
        1:       win = 24'd1;
        2:       win = {pcwrl_pkg::WindowW{1'b1}};
        default: win = pcwrl_pkg::WindowW'($urandom_range(2, 60));
      endcase
      configure(en, lim, win);
      random_traffic(170, $urandom_range(1, 24), $urandom_range(2, 25));
    end

    // The result side holds off while requests keep coming at full rate.
    configure(1'b1, 8'd3, 24'd40);
    send_idles  = 1'b0;
    take_stalls = 1'b1;
    hold_order  = 300;
    random_traffic(40, 6, 5);
    drain_results();
    send_idles = 1'b1;
    random_traffic(30, 20, 5);

    // One client counted all the way to the top of the count range.
    configure(1'b1, 8'd255, {pcwrl_pkg::WindowW{1'b1}});
    random_traffic(280, 1, 0);

    drain_results();
    repeat (6) @(posedge clk_i);
    if (book.mismatches == 0 && book.verdicts_due.size() == 0)
      $display("per_client_window_rate_limiter_test OK");
    else
      $display("per_client_window_rate_limiter_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pcwrl_pkg.sv
sv/pcwrl_intf.sv
sv/per_client_window_rate_limiter.sv
tb/per_client_window_rate_limiter_test.sv
